// ===== hw/rtl/tsjq_pkg.sv =====
// Shared types and constants for the touch sample jump qualifier.
package tsjq_pkg;

    localparam int COORD_BITS    = 12;
    localparam int PRESS_BITS    = 12;
    localparam int SETTING_BITS  = 7;
    localparam int SIZE_BITS     = 12;
    localparam int COUNT_BITS    = 32;
    localparam int HISTORY_DEPTH = 3;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [SETTING_BITS-1:0] SETTING_MAX         = SETTING_BITS'(100);
    localparam logic [SETTING_BITS-1:0] JUMP_THRESHOLD_INIT = SETTING_BITS'(4);
    localparam logic [SETTING_BITS-1:0] BORDER_WIDTH_INIT   = SETTING_BITS'(0);
    localparam logic [SIZE_BITS-1:0]    SCREEN_WIDTH_INIT   = SIZE_BITS'(800);
    localparam logic [SIZE_BITS-1:0]    SCREEN_HEIGHT_INIT  = SIZE_BITS'(480);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_JUMP_THRESHOLD = 2'd0,
        CFG_BORDER_WIDTH   = 2'd1,
        CFG_SCREEN_WIDTH   = 2'd2,
        CFG_SCREEN_HEIGHT  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [PRESS_BITS-1:0] pressure;
    } sample_beat_t;

    typedef struct packed {
        logic                  outside;
        logic                  jump;
        logic                  pen_released;
        logic [COUNT_BITS-1:0] sample_total;
        logic [COUNT_BITS-1:0] outside_total;
        logic [COUNT_BITS-1:0] jump_total;
    } result_beat_t;

    typedef struct packed {
        logic [SETTING_BITS-1:0] jump_threshold;
        logic [SETTING_BITS-1:0] border_width;
        logic [SIZE_BITS-1:0]    screen_width;
        logic [SIZE_BITS-1:0]    screen_height;
    } cfg_t;

endpackage

// ===== hw/rtl/tsjq_cfg_regs.sv =====
// Configuration register file for the jump qualifier.
module tsjq_cfg_regs
    import tsjq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t                    cfg_reg;
    cfg_t                    cfg_next;
    logic [SETTING_BITS-1:0] setting_val;

    assign setting_val = cfg_data[SETTING_BITS-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_JUMP_THRESHOLD:
                begin
                    // out-of-range settings are dropped
                    if (setting_val <= SETTING_MAX)
                        cfg_next.jump_threshold = setting_val;
                end
                CFG_BORDER_WIDTH:
                begin
                    if (setting_val <= SETTING_MAX)
                        cfg_next.border_width = setting_val;
                end
                CFG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data[SIZE_BITS-1:0];
                CFG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_data[SIZE_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.jump_threshold <= JUMP_THRESHOLD_INIT;
            cfg_reg.border_width   <= BORDER_WIDTH_INIT;
            cfg_reg.screen_width   <= SCREEN_WIDTH_INIT;
            cfg_reg.screen_height  <= SCREEN_HEIGHT_INIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/tsjq_qualifier.sv =====
// Border test, coordinate history, jump check and counters.
module tsjq_qualifier
    import tsjq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  sample_beat_t sample,
    input  cfg_t         cfg,
    output result_beat_t result_next
);

    logic [COORD_BITS-1:0] x_hist_reg  [HISTORY_DEPTH];
    logic [COORD_BITS-1:0] y_hist_reg  [HISTORY_DEPTH];
    logic [COORD_BITS-1:0] x_hist_next [HISTORY_DEPTH];
    logic [COORD_BITS-1:0] y_hist_next [HISTORY_DEPTH];
    logic [COORD_BITS-1:0] x_shift     [HISTORY_DEPTH];
    logic [COORD_BITS-1:0] y_shift     [HISTORY_DEPTH];

    logic [COUNT_BITS-1:0] sample_cnt_reg, sample_cnt_next;
    logic [COUNT_BITS-1:0] outside_cnt_reg, outside_cnt_next;
    logic [COUNT_BITS-1:0] jump_cnt_reg, jump_cnt_next;

    logic                  right_hit, bottom_hit, outside;
    logic                  oldest_set, jump, released;
    logic [COORD_BITS-1:0] d21, d10, d20;
    logic [COORD_BITS-1:0] thresh;

    function automatic logic [COORD_BITS-1:0] abs_gap(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        abs_gap = (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [COORD_BITS-1:0] cheb(
        input logic [COORD_BITS-1:0] xa,
        input logic [COORD_BITS-1:0] ya,
        input logic [COORD_BITS-1:0] xb,
        input logic [COORD_BITS-1:0] yb
    );
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        dx   = abs_gap(xa, xb);
        dy   = abs_gap(ya, yb);
        cheb = (dx > dy) ? dx : dy;
    endfunction

    // limit test is off on an axis whose margin exceeds the screen size
    function automatic logic past_limit(
        input logic [COORD_BITS-1:0]   v,
        input logic [SIZE_BITS-1:0]    size,
        input logic [SETTING_BITS-1:0] border
    );
        logic [SIZE_BITS-1:0] bw;
        logic [SIZE_BITS-1:0] lim;
        bw  = SIZE_BITS'(border);
        lim = size - bw;
        if (bw > size)
            past_limit = 1'b0;
        else
            past_limit = (COORD_BITS'(lim) < v);
    endfunction

    always_comb
    begin
        right_hit  = past_limit(sample.pos_x, cfg.screen_width, cfg.border_width);
        bottom_hit = past_limit(sample.pos_y, cfg.screen_height, cfg.border_width);
        outside    = (sample.pos_x < COORD_BITS'(cfg.border_width))
                  || (sample.pos_y < COORD_BITS'(cfg.border_width))
                  || right_hit || bottom_hit;

        x_shift[0] = sample.pos_x;
        y_shift[0] = sample.pos_y;
        for (int i = 1; i < HISTORY_DEPTH; i++)
        begin
            x_shift[i] = x_hist_reg[i-1];
            y_shift[i] = y_hist_reg[i-1];
        end

        thresh     = COORD_BITS'(cfg.jump_threshold);
        oldest_set = (x_shift[2] != '0) || (y_shift[2] != '0);
        d21        = cheb(x_shift[2], y_shift[2], x_shift[1], y_shift[1]);
        d10        = cheb(x_shift[1], y_shift[1], x_shift[0], y_shift[0]);
        d20        = cheb(x_shift[2], y_shift[2], x_shift[0], y_shift[0]);
        jump       = !outside && oldest_set && (d21 > thresh)
                  && ((d10 > thresh) || (d20 > thresh));
        released   = !outside && (sample.pressure == '0);

        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            if (outside)
            begin
                x_hist_next[i] = x_hist_reg[i];
                y_hist_next[i] = y_hist_reg[i];
            end
            else if (released)
            begin
                x_hist_next[i] = '0;
                y_hist_next[i] = '0;
            end
            else
            begin
                x_hist_next[i] = x_shift[i];
                y_hist_next[i] = y_shift[i];
            end
        end

        sample_cnt_next  = sample_cnt_reg + COUNT_BITS'(1);
        outside_cnt_next = outside_cnt_reg + COUNT_BITS'(outside);
        jump_cnt_next    = jump_cnt_reg + COUNT_BITS'(jump);

        result_next.outside       = outside;
        result_next.jump          = jump;
        result_next.pen_released  = released;
        result_next.sample_total  = sample_cnt_next;
        result_next.outside_total = outside_cnt_next;
        result_next.jump_total    = jump_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                x_hist_reg[i] <= '0;
                y_hist_reg[i] <= '0;
            end
            sample_cnt_reg  <= '0;
            outside_cnt_reg <= '0;
            jump_cnt_reg    <= '0;
        end
        else if (advance)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                x_hist_reg[i] <= x_hist_next[i];
                y_hist_reg[i] <= y_hist_next[i];
            end
            sample_cnt_reg  <= sample_cnt_next;
            outside_cnt_reg <= outside_cnt_next;
            jump_cnt_reg    <= jump_cnt_next;
        end
    end

endmodule

// ===== hw/rtl/touch_sample_jump_qualifier_core.sv =====
// Top level of the touch sample jump qualifier: input stage, qualifier, result stage.
// A sample beat accepted into the input register moves into the result register
// once the result slot is free. Throughput: one sample beat per cycle while the
// result channel does not stall; the input and result registers form a two-entry
// pipeline, so a waiting result blocks new samples only when the input stage is full.
// Reset (rst_n low, async): history and counters cleared, config back to defaults.
module touch_sample_jump_qualifier_core
    import tsjq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // sample channel
    input  logic                     sample_valid,
    output logic                     sample_stall,
    input  sample_beat_t             sample,
    // result channel
    output logic                     result_valid,
    input  logic                     result_stall,
    output result_beat_t             result,
    // config write port
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t         cfg;
    sample_beat_t in_beat_reg;
    logic         in_valid_reg;
    result_beat_t res_beat_reg;
    logic         res_valid_reg;
    result_beat_t res_beat_next;
    logic         res_free;
    logic         advance;
    logic         in_take;

    tsjq_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // result slot is free when empty or being drained this cycle
    assign res_free     = !res_valid_reg || !result_stall;
    // staged sample moves into the result slot; history/counters commit here
    assign advance      = in_valid_reg && res_free;
    // input stage holds only when its beat cannot move on
    assign sample_stall = in_valid_reg && !res_free;
    assign in_take      = sample_valid && !sample_stall;

    tsjq_qualifier u_qual (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .sample      (in_beat_reg),
        .cfg         (cfg),
        .result_next (res_beat_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (!sample_stall)
                in_valid_reg <= sample_valid;
            if (res_free)
                res_valid_reg <= in_valid_reg;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_beat_reg <= sample;
        if (advance)
            res_beat_reg <= res_beat_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_beat_reg;

endmodule

// ===== hw/rtl/tsjq_checker.sv =====
// Port-level checker for the jump qualifier, bound to the top level.
module tsjq_checker
    import tsjq_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         sample_stall,
    input logic         result_valid,
    input logic         result_stall,
    input result_beat_t result
);

    logic                  seen_reg;
    logic [COUNT_BITS-1:0] last_sample_reg;
    logic [COUNT_BITS-1:0] last_outside_reg;
    logic                  res_take;

    assign res_take = result_valid && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg         <= 1'b0;
            last_sample_reg  <= '0;
            last_outside_reg <= '0;
        end
        else if (res_take)
        begin
            seen_reg         <= 1'b1;
            last_sample_reg  <= result.sample_total;
            last_outside_reg <= result.outside_total;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_valid && result_stall)
        else $error("sample channel stalled without a blocked result");

    a_outside_flags: assert property (@(posedge clk) disable iff (!rst_n)
        res_take && result.outside |-> !result.jump && !result.pen_released)
        else $error("outside beat carries jump or release flag");

    a_sample_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |-> result.sample_total == last_sample_reg + COUNT_BITS'(1))
        else $error("sample total not one past previous beat");

    a_outside_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_take && seen_reg |->
            result.outside_total == last_outside_reg + COUNT_BITS'(result.outside))
        else $error("outside total does not follow outside flag");

endmodule

bind touch_sample_jump_qualifier_core tsjq_checker u_tsjq_checker (.*);
